[rtl/core/omsrs_pkg.sv]
package omsrs_pkg;

    localparam int FAN = 32;

    localparam logic signed [31:0] LOW_SENTINEL  = -32'sd2147483647;
    localparam logic signed [31:0] HIGH_SENTINEL = 32'sd2147483647;

    typedef enum logic [2:0] {
        OP_INSERT      = 3'd0,
        OP_REMOVE      = 3'd1,
        OP_RANK        = 3'd2,
        OP_SELECT      = 3'd3,
        OP_PREDECESSOR = 3'd4,
        OP_SUCCESSOR   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REDUCE,
        ST_DONE
    } state_t;

    // What a cell shows its neighbours
    typedef struct packed {
        logic signed [31:0] value;
        logic               valid;
        logic               lt;
        logic               gtv;
    } nbr_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic               insert_en;
        logic               remove_en;
        op_t                op;
        logic signed [31:0] operand;
    } cell_ctrl_t;

    // One-hot hit flag with its data, OR-reduced over the row
    typedef struct packed {
        logic        hit;
        logic [31:0] data;
    } leaf_t;

    // Virtual neighbours beyond both ends of the row
    localparam nbr_t NBR_HEAD = '{value: '0, valid: 1'b1, lt: 1'b1, gtv: 1'b0};
    localparam nbr_t NBR_TAIL = '{value: '0, valid: 1'b0, lt: 1'b0, gtv: 1'b0};

    function automatic int level_count(input int n, input int l);
        int c;
        c = n;
        for (int k = 0; k < l; k++) begin
            c = (c + FAN - 1) / FAN;
        end
        return c;
    endfunction

    function automatic int tree_levels(input int n);
        int c;
        int l;
        c = n;
        l = 0;
        while (c > 1) begin
            c = (c + FAN - 1) / FAN;
            l++;
        end
        if (l == 0) begin
            l = 1;
        end
        return l;
    endfunction

    // Position of the first node of level l (levels from 1) in the flat node array
    function automatic int level_offset(input int n, input int l);
        int s;
        s = 0;
        for (int k = 1; k < l; k++) begin
            s += level_count(n, k);
        end
        return s;
    endfunction

endpackage

[rtl/core/omsrs_cell.sv]
module omsrs_cell #(
    parameter int INDEX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  omsrs_pkg::cell_ctrl_t  ctrl,
    input  omsrs_pkg::nbr_t        prev,
    input  omsrs_pkg::nbr_t        next,
    output omsrs_pkg::nbr_t        own,
    output omsrs_pkg::leaf_t       leaf
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               valid_reg;
    logic               valid_next;
    omsrs_pkg::leaf_t   leaf_reg;
    omsrs_pkg::leaf_t   leaf_next;

    logic lt;
    logic gtv;
    logic self_gt;
    logic prev_gt;

    assign lt      = valid_reg && (value_reg < ctrl.operand);
    assign gtv     = valid_reg && (value_reg > ctrl.operand);
    assign self_gt = !valid_reg || gtv;
    assign prev_gt = !prev.valid || prev.gtv;

    assign own  = '{value: value_reg, valid: valid_reg, lt: lt, gtv: gtv};
    assign leaf = leaf_reg;

    // Insert shifts the upper part of the row up by one, remove pulls it down
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert_en && self_gt)
        begin
            value_next = prev_gt ? prev.value : ctrl.operand;
            valid_next = valid_reg | prev.valid;
        end
        else if (ctrl.remove_en && !lt)
        begin
            value_next = next.value;
            valid_next = next.valid;
        end
    end

    always_comb
    begin
        leaf_next = '0;
        case (ctrl.op)
            omsrs_pkg::OP_REMOVE:
            begin
                leaf_next.hit = !lt && prev.lt && valid_reg && (value_reg == ctrl.operand);
            end
            omsrs_pkg::OP_RANK:
            begin
                leaf_next.hit = !lt && prev.lt;
                leaf_next.data = leaf_next.hit ? 32'(INDEX) : '0;
            end
            omsrs_pkg::OP_SELECT:
            begin
                leaf_next.hit = valid_reg && (ctrl.operand == 32'(INDEX + 1));
                leaf_next.data = leaf_next.hit ? value_reg : '0;
            end
            omsrs_pkg::OP_PREDECESSOR:
            begin
                leaf_next.hit = lt && !next.lt;
                leaf_next.data = leaf_next.hit ? value_reg : '0;
            end
            omsrs_pkg::OP_SUCCESSOR:
            begin
                leaf_next.hit = gtv && !prev.gtv;
                leaf_next.data = leaf_next.hit ? value_reg : '0;
            end
            default:
            begin
                leaf_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        leaf_reg  <= leaf_next;
    end

endmodule

[rtl/core/omsrs_or_tree.sv]
module omsrs_or_tree #(
    parameter int N = 1024
) (
    input  logic             clk,
    input  omsrs_pkg::leaf_t leaves [N],
    output omsrs_pkg::leaf_t root
);

    localparam int LEVELS = omsrs_pkg::tree_levels(N);
    localparam int TOTAL  = omsrs_pkg::level_offset(N, LEVELS + 1);

    omsrs_pkg::leaf_t node_reg [TOTAL];

    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_level
        localparam int CNT  = omsrs_pkg::level_count(N, l);
        localparam int PREV = omsrs_pkg::level_count(N, l - 1);
        localparam int OFF  = omsrs_pkg::level_offset(N, l);

        for (genvar j = 0; j < CNT; j++)
        begin : g_node
            localparam int FIRST = j * omsrs_pkg::FAN;
            localparam int LAST  = (FIRST + omsrs_pkg::FAN < PREV) ?
                                   FIRST + omsrs_pkg::FAN : PREV;
            omsrs_pkg::leaf_t acc;

            if (l == 1)
            begin : g_leaves
                always_comb
                begin
                    acc = '0;
                    for (int k = FIRST; k < LAST; k++)
                    begin
                        acc = acc | leaves[k];
                    end
                end
            end
            else
            begin : g_inner
                localparam int POFF = omsrs_pkg::level_offset(N, l - 1);
                always_comb
                begin
                    acc = '0;
                    for (int k = FIRST; k < LAST; k++)
                    begin
                        acc = acc | node_reg[POFF + k];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                node_reg[OFF + j] <= acc;
            end
        end
    end

    assign root = node_reg[TOTAL - 1];

endmodule

[rtl/core/ordered_multiset_rank_select.sv]
// Ordered multiset with rank and select queries.
//
// Input channel (s_axis_*): one beat carries one operation: insert, remove, rank,
// select, predecessor or successor, with a signed 32-bit operand. Insert and
// remove change the stored multiset and give no output beat; the four queries
// give exactly one output beat each (m_axis_*), carrying the answer. Op codes six
// and seven are dropped with no effect.
//
// The values sit sorted in a row of CAPACITY cells, one value per cell. Every cell
// compares its value against the broadcast operand in the same cycle and talks
// only to its two neighbours. Insert shifts the row up in that one cycle. Queries
// and remove mark at most one cell, and a registered OR tree of fan-in 32 with
// L = ceil(log32(CAPACITY)) levels brings that cell's data to the root.
//
// Timing: one item at a time. Insert and ignored ops pass through the execute step
// and go back to idle for the next tready; remove and queries then step through the
// tree levels in the reduce state, one level at a time, and finish in the done step.
// A finished answer waits in the output register and new beats are accepted while it
// waits; a stalled receiver holds only a query that reaches the done step while that
// register is still full. Reset empties the multiset and drops any pending answer.
module ordered_multiset_rank_select #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [2:0] op, [34:3] operand_value, [39:35] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] answer
);

    localparam int LEVELS = omsrs_pkg::tree_levels(CAPACITY);
    localparam int LVL_W  = $clog2(LEVELS + 1);

    omsrs_pkg::state_t state_reg;
    omsrs_pkg::state_t state_next;
    omsrs_pkg::op_t    op_reg;
    logic signed [31:0] operand_reg;
    logic [LVL_W-1:0]  lvl_cnt_reg;
    logic [LVL_W-1:0]  lvl_cnt_next;
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;
    logic [31:0]       answer;
    logic              load_out;
    logic              needs_answer;

    omsrs_pkg::cell_ctrl_t ctrl;
    omsrs_pkg::nbr_t       cell_nbr  [CAPACITY];
    omsrs_pkg::leaf_t      cell_leaf [CAPACITY];
    omsrs_pkg::leaf_t      root;

    logic in_beat;
    logic out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------------------------------------------------------- cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        omsrs_pkg::nbr_t prev_nbr;
        omsrs_pkg::nbr_t next_nbr;

        if (i == 0)
        begin : g_head
            assign prev_nbr = omsrs_pkg::NBR_HEAD;
        end
        else
        begin : g_mid_prev
            assign prev_nbr = cell_nbr[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_nbr = omsrs_pkg::NBR_TAIL;
        end
        else
        begin : g_mid_next
            assign next_nbr = cell_nbr[i + 1];
        end

        omsrs_cell #(
            .INDEX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  (prev_nbr),
            .next  (next_nbr),
            .own   (cell_nbr[i]),
            .leaf  (cell_leaf[i])
        );
    end

    omsrs_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .clk    (clk),
        .leaves (cell_leaf),
        .root   (root)
    );

    // ---------------------------------------------------------------- answer
    // Resolve the tree root; no hit means the sentinel (or rank past a full row)
    always_comb
    begin
        answer = '0;
        case (op_reg)
            omsrs_pkg::OP_RANK:
            begin
                answer = root.hit ? root.data + 32'd1 : 32'(CAPACITY + 1);
            end
            omsrs_pkg::OP_SELECT:
            begin
                if (root.hit)
                begin
                    answer = root.data;
                end
                else if (operand_reg < 32'sd1)
                begin
                    answer = omsrs_pkg::LOW_SENTINEL;
                end
                else
                begin
                    answer = omsrs_pkg::HIGH_SENTINEL;
                end
            end
            omsrs_pkg::OP_PREDECESSOR:
            begin
                answer = root.hit ? root.data : omsrs_pkg::LOW_SENTINEL;
            end
            omsrs_pkg::OP_SUCCESSOR:
            begin
                answer = root.hit ? root.data : omsrs_pkg::HIGH_SENTINEL;
            end
            default:
            begin
                answer = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= omsrs_pkg::ST_IDLE;
            lvl_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            lvl_cnt_reg <= lvl_cnt_next;
        end
    end

    // Hold the operation for the whole item
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg      <= omsrs_pkg::op_t'(s_axis_tdata[2:0]);
            operand_reg <= s_axis_tdata[34:3];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lvl_cnt_next   = lvl_cnt_reg;
        s_axis_tready  = 1'b0;
        load_out       = 1'b0;
        ctrl.insert_en = 1'b0;
        ctrl.remove_en = 1'b0;
        ctrl.op        = op_reg;
        ctrl.operand   = operand_reg;
        needs_answer   = (op_reg == omsrs_pkg::OP_RANK)
                      || (op_reg == omsrs_pkg::OP_SELECT)
                      || (op_reg == omsrs_pkg::OP_PREDECESSOR)
                      || (op_reg == omsrs_pkg::OP_SUCCESSOR);
        case (state_reg)
            omsrs_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = omsrs_pkg::ST_EXEC;
                end
            end
            omsrs_pkg::ST_EXEC:
            begin
                // Leaves latch this cycle; insert shifts the row now, unless full
                ctrl.insert_en = (op_reg == omsrs_pkg::OP_INSERT)
                              && !cell_nbr[CAPACITY - 1].valid;
                lvl_cnt_next = '0;
                if (needs_answer || op_reg == omsrs_pkg::OP_REMOVE)
                begin
                    state_next = omsrs_pkg::ST_REDUCE;
                end
                else
                begin
                    state_next = omsrs_pkg::ST_IDLE;
                end
            end
            omsrs_pkg::ST_REDUCE:
            begin
                lvl_cnt_next = lvl_cnt_reg + 1'b1;
                if (lvl_cnt_reg == LVL_W'(LEVELS - 1))
                begin
                    state_next = omsrs_pkg::ST_DONE;
                end
            end
            omsrs_pkg::ST_DONE:
            begin
                if (op_reg == omsrs_pkg::OP_REMOVE)
                begin
                    // Pull the row down only when the value was found
                    ctrl.remove_en = root.hit;
                    state_next     = omsrs_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = omsrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = omsrs_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_beat)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= answer;
        end
    end

    // ---------------------------------------------------------------- assertions
    a_one_item_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready
    ) else $error("input beat accepted while an item is in flight");

    a_answer_from_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == omsrs_pkg::ST_DONE)
    ) else $error("answer presented outside the final step");

    a_remove_hits_stored: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctrl.remove_en |-> cell_nbr[0].valid
    ) else $error("remove found a value in an empty row");

    a_no_remove_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == omsrs_pkg::ST_DONE && op_reg == omsrs_pkg::OP_REMOVE) |-> !load_out
    ) else $error("remove produced an answer beat");

endmodule
